// ----- sv/hcbd_pkg.sv -----
package hcbd_pkg;

	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [4:0] HEX_NONE = 5'd16;

	localparam logic [2:0] PH_SIZE = 3'd0;
	localparam logic [2:0] PH_EXT  = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_CR   = 3'd3;
	localparam logic [2:0] PH_LF   = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;
	localparam logic [2:0] PH_ERR  = 3'd6;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_NO_DIGITS = 3'd1;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
	localparam logic [2:0] STATUS_SIZE_CUT  = 3'd3;
	localparam logic [2:0] STATUS_DATA_CUT  = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       finished;
		logic [2:0] status;
		logic       is_last;
	} result_t;

	typedef struct packed {
		logic [2:0]           phase;
		logic [SIZE_BITS-1:0] count;
		logic                 digit_seen;
		logic [2:0]           error_code;
	} dec_state_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h41 + 8'd10);
		end
		return v;
	endfunction

endpackage

// ----- sv/hcbd_fsm.sv -----
module hcbd_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  hcbd_pkg::item_t  item,
	output hcbd_pkg::result_t result
);

	hcbd_pkg::dec_state_t st_q;
	hcbd_pkg::dec_state_t st_d;
	hcbd_pkg::dec_state_t st_nx;
	hcbd_pkg::dec_state_t st_rst;

	function automatic hcbd_pkg::dec_state_t end_line(input hcbd_pkg::dec_state_t s);
		hcbd_pkg::dec_state_t r;
		r = s;
		r.phase = (s.count == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
		return r;
	endfunction

	function automatic hcbd_pkg::dec_state_t size_byte(input hcbd_pkg::dec_state_t s,
			input logic [7:0] c);
		hcbd_pkg::dec_state_t r;
		logic [4:0] d;
		r = s;
		d = hcbd_pkg::hex_value(c);
		if (d != hcbd_pkg::HEX_NONE) begin
			if (s.count[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
				r.error_code = hcbd_pkg::STATUS_OVERFLOW;
				r.phase = hcbd_pkg::PH_ERR;
			end else begin
				r.count = {s.count[hcbd_pkg::SIZE_BITS-5:0], d[3:0]};
				r.digit_seen = 1'b1;
			end
		end else if (!s.digit_seen) begin
			r.error_code = hcbd_pkg::STATUS_NO_DIGITS;
			r.phase = hcbd_pkg::PH_ERR;
		end else begin
			r.phase = hcbd_pkg::PH_EXT;
			if (c == hcbd_pkg::CHAR_LF) begin
				r = end_line(r);
			end
		end
		return r;
	endfunction

	always_comb begin
		st_rst = '0;
		st_rst.phase = hcbd_pkg::PH_SIZE;
	end

	always_comb begin
		hcbd_pkg::dec_state_t fresh;
		logic valid;
		fresh = st_q;
		fresh.phase = hcbd_pkg::PH_SIZE;
		fresh.digit_seen = 1'b0;
		fresh.count = '0;
		st_nx = st_q;
		valid = 1'b0;
		unique case (st_q.phase)
			hcbd_pkg::PH_SIZE: begin
				st_nx = size_byte(st_q, item.in_byte);
			end
			hcbd_pkg::PH_EXT: begin
				if (item.in_byte == hcbd_pkg::CHAR_LF) begin
					st_nx = end_line(st_q);
				end
			end
			hcbd_pkg::PH_DATA: begin
				valid = 1'b1;
				st_nx.count = st_q.count - (hcbd_pkg::SIZE_BITS)'(1);
				if (st_nx.count == '0) begin
					st_nx.phase = hcbd_pkg::PH_CR;
				end
			end
			hcbd_pkg::PH_CR: begin
				if (item.in_byte == hcbd_pkg::CHAR_CR) begin
					st_nx.phase = hcbd_pkg::PH_LF;
				end else if (item.in_byte == hcbd_pkg::CHAR_LF) begin
					st_nx = fresh;
				end else begin
					st_nx = size_byte(fresh, item.in_byte);
				end
			end
			hcbd_pkg::PH_LF: begin
				if (item.in_byte == hcbd_pkg::CHAR_LF) begin
					st_nx = fresh;
				end else begin
					st_nx = size_byte(fresh, item.in_byte);
				end
			end
			hcbd_pkg::PH_DONE: begin
				st_nx = st_q;
			end
			default: begin
				st_nx.phase = hcbd_pkg::PH_ERR;
			end
		endcase

		if (item.in_last && st_nx.phase != hcbd_pkg::PH_ERR
				&& st_nx.phase != hcbd_pkg::PH_DONE) begin
			if (st_nx.phase == hcbd_pkg::PH_EXT
					|| (st_nx.phase == hcbd_pkg::PH_SIZE && st_nx.digit_seen)) begin
				st_nx.error_code = hcbd_pkg::STATUS_SIZE_CUT;
			end else if (st_nx.phase == hcbd_pkg::PH_DATA) begin
				st_nx.error_code = hcbd_pkg::STATUS_DATA_CUT;
			end else begin
				st_nx.error_code = hcbd_pkg::STATUS_NO_DIGITS;
			end
			st_nx.phase = hcbd_pkg::PH_ERR;
		end

		result.out_byte = valid ? item.in_byte : 8'd0;
		result.out_valid = valid;
		result.finished = (st_nx.phase == hcbd_pkg::PH_DONE);
		result.status = st_nx.error_code;
		result.is_last = item.in_last;

		st_d = item.in_last ? st_rst : st_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_rst;
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

endmodule

// ----- sv/http_chunked_body_decoder.sv -----
// An input transfer is captured in the input register, decoded, and its result captured in the result register.
// Throughput: one byte per cycle; the input register, the decode step and the result register
// form a two-stage pipeline, and the input stalls only while both stages are held.
// Reset: arst_n clears both stage valid flags and returns the decoder to the start of a size line
// with no error; a byte flagged as last also returns the decoder to that state.
module http_chunked_body_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  hcbd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output hcbd_pkg::result_t result
);

	logic              valid_s1;
	hcbd_pkg::item_t   item_s1;
	logic              advance;
	hcbd_pkg::result_t step_res;
	logic              out_valid_q;
	hcbd_pkg::result_t out_q;

	assign advance = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	hcbd_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !result_stall) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	a_payload_not_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.out_valid) |-> !result.finished)
		else $error("payload byte marked as finished");

	a_finished_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.finished) |-> (result.status == hcbd_pkg::STATUS_OK))
		else $error("finished result carries an error status");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("decoded byte did not reach the result register");

endmodule

// ----- bench/http_chunked_body_decoder_test.sv -----
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;
	import hcbd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int BODY_ITEMS = 650;

	typedef struct packed {
		item_t   it;
		logic    known;
		result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	stim_row_t body_rows[$];
	result_t pending_results[$];
	int unsigned cycles = 0;
	int errors = 0;
	int taken = 0;
	int checked = 0;

	// Decoder state as the bench sees it.
	logic [2:0] dec_phase;
	logic [SIZE_BITS-1:0] dec_count;
	logic dec_seen;
	logic [2:0] dec_err;

	http_chunked_body_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	task automatic report_mismatch(input string what);
		if (errors < 100) begin
			$display("mismatch at cycle %0d: %s", cycles, what);
		end
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [7:0] folded;
		folded = c | 8'h20;
		if (c >= 8'h30 && c <= 8'h39) begin
			return 5'(c - 8'h30);
		end
		if (folded >= 8'h61 && folded <= 8'h66) begin
			return 5'(folded - 8'h61 + 8'd10);
		end
		return HEX_NONE;
	endfunction

	function automatic void restart_size();
		dec_phase = PH_SIZE;
		dec_seen = 1'b0;
		dec_count = '0;
	endfunction

	function automatic void fail_with(input logic [2:0] code);
		dec_err = code;
		dec_phase = PH_ERR;
	endfunction

	function automatic void close_size_line();
		dec_phase = (dec_count == '0) ? PH_DONE : PH_DATA;
	endfunction

	function automatic void size_char(input logic [7:0] c);
		logic [4:0] d;
		d = nibble_of(c);
		if (d != HEX_NONE) begin
			// A ninth significant nibble would push the size past its width.
			if (dec_count[SIZE_BITS-1 -: 4] != 4'd0) begin
				fail_with(STATUS_OVERFLOW);
			end else begin
				dec_count = {dec_count[SIZE_BITS-5:0], d[3:0]};
				dec_seen = 1'b1;
			end
		end else if (!dec_seen) begin
			fail_with(STATUS_NO_DIGITS);
		end else if (c == CHAR_LF) begin
			close_size_line();
		end else begin
			dec_phase = PH_EXT;
		end
	endfunction

	function automatic result_t decode_byte(input item_t it);
		result_t r;
		logic [7:0] c;
		c = it.in_byte;
		r = '0;
		case (dec_phase)
			PH_SIZE: size_char(c);
			PH_EXT: begin
				if (c == CHAR_LF) begin
					close_size_line();
				end
			end
			PH_DATA: begin
				r.out_valid = 1'b1;
				r.out_byte = c;
				dec_count = dec_count - 1'b1;
				if (dec_count == '0) begin
					dec_phase = PH_CR;
				end
			end
			PH_CR: begin
				if (c == CHAR_CR) begin
					dec_phase = PH_LF;
				end else begin
					restart_size();
					if (c != CHAR_LF) begin
						size_char(c);
					end
				end
			end
			PH_LF: begin
				restart_size();
				if (c != CHAR_LF) begin
					size_char(c);
				end
			end
			PH_DONE: ;
			default: dec_phase = PH_ERR;
		endcase
		if (it.in_last && dec_phase != PH_ERR && dec_phase != PH_DONE) begin
			if (dec_phase == PH_EXT || (dec_phase == PH_SIZE && dec_seen)) begin
				fail_with(STATUS_SIZE_CUT);
			end else if (dec_phase == PH_DATA) begin
				fail_with(STATUS_DATA_CUT);
			end else begin
				fail_with(STATUS_NO_DIGITS);
			end
		end
		r.finished = (dec_phase == PH_DONE);
		r.status = dec_err;
		r.is_last = it.in_last;
		if (it.in_last) begin
			restart_size();
			dec_err = STATUS_OK;
		end
		return r;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic l, input logic k,
			input logic [7:0] ob = 8'h00, input logic ov = 1'b0, input logic fin = 1'b0,
			input logic [2:0] st = STATUS_OK);
		stim_row_t row;
		row.it.in_byte = b;
		row.it.in_last = l;
		row.known = k;
		row.want = {ob, ov, fin, st, l};
		body_rows.push_back(row);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return 8'h30 + 8'(v);
		end
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	// Mostly well-formed messages with random sizes, extensions, line ends and
	// trailers; the rest are noise, cut short, corrupted or oversized.
	task automatic compose_message();
		logic [7:0] msg[$];
		logic [7:0] b;
		int kind;
		int chunks;
		int size;
		int n;
		int i;
		int k;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
		end else begin
			chunks = $urandom_range(0, 3);
			for (i = 0; i <= chunks; i++) begin
				if (i == chunks) begin
					size = 0;
				end else if ($urandom_range(0, 9) == 0) begin
					size = $urandom_range(16, 80);
				end else begin
					size = $urandom_range(1, 6);
				end
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) msg.push_back(8'h30);
				n = 1;
				while ((size >> (4 * n)) != 0) n++;
				for (k = n - 1; k >= 0; k--) begin
					msg.push_back(hex_char(4'((size >> (4 * k)) & 15)));
				end
				if ($urandom_range(0, 3) == 0) begin
					msg.push_back(8'h3b);
					repeat ($urandom_range(0, 3)) begin
						b = 8'($urandom);
						msg.push_back(b == CHAR_LF ? 8'h3d : b);
					end
				end
				if ($urandom_range(0, 3) != 0) begin
					msg.push_back(CHAR_CR);
				end
				msg.push_back(CHAR_LF);
				if (i < chunks) begin
					repeat (size) msg.push_back(8'($urandom));
					case ($urandom_range(0, 7))
						0: msg.push_back(CHAR_LF);
						1: msg.push_back(CHAR_CR);
						2: ;
						default: begin
							msg.push_back(CHAR_CR);
							msg.push_back(CHAR_LF);
						end
					endcase
				end
			end
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
				msg.push_back(8'($urandom));
			end
			if (kind < 16) begin
				msg = msg[0:$urandom_range(0, msg.size() - 1)];
			end else if (kind < 22) begin
				msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
			end else if (kind < 26) begin
				for (k = 0; k < 9; k++) begin
					msg.push_front(hex_char(k == 8 ? 4'($urandom_range(1, 15)) : 4'($urandom)));
				end
			end
		end
		for (k = 0; k < msg.size(); k++) begin
			add_row(msg[k], k == msg.size() - 1, 1'b0);
		end
	endtask

	initial begin
		int next_row;
		stim_row_t on_bus;
		result_t guess;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		restart_size();
		dec_err = STATUS_OK;

		// A non-hex byte before any digit fails; later bytes are ignored.
		add_row(8'h58, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, STATUS_NO_DIGITS);
		add_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, STATUS_NO_DIGITS);
		// Nine hex digits overflow the size.
		add_row(8'h46, 1'b0, 1'b0);
		add_row(8'h66, 1'b0, 1'b0);
		add_row(8'h46, 1'b0, 1'b0);
		add_row(8'h66, 1'b0, 1'b0);
		add_row(8'h46, 1'b0, 1'b0);
		add_row(8'h66, 1'b0, 1'b0);
		add_row(8'h46, 1'b0, 1'b0);
		add_row(8'h66, 1'b0, 1'b0);
		add_row(8'h46, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, STATUS_OVERFLOW);
		// One data byte, a bare terminator, then an ignored byte after it.
		add_row(8'h31, 1'b0, 1'b0);
		add_row(CHAR_LF, 1'b0, 1'b0);
		add_row(8'hff, 1'b0, 1'b1, 8'hff, 1'b1, 1'b0, STATUS_OK);
		add_row(8'h30, 1'b0, 1'b0);
		add_row(CHAR_LF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_OK);
		add_row(8'h80, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_OK);
		// The message ends with a data byte still owed.
		add_row(8'h32, 1'b0, 1'b0);
		add_row(CHAR_CR, 1'b0, 1'b0);
		add_row(CHAR_LF, 1'b0, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0, STATUS_DATA_CUT);
		// The message ends inside an extension.
		add_row(8'h41, 1'b0, 1'b0);
		add_row(8'h3b, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, STATUS_SIZE_CUT);
		// The message ends between chunks without a terminator.
		add_row(8'h31, 1'b0, 1'b0);
		add_row(CHAR_LF, 1'b0, 1'b0);
		add_row(8'h7e, 1'b0, 1'b0);
		add_row(CHAR_CR, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, STATUS_NO_DIGITS);
		while (body_rows.size() < BODY_ITEMS) compose_message();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		next_row = 0;
		while (taken < body_rows.size()) begin
			@(posedge clk);
			if (item_valid && !item_stall) begin
				guess = decode_byte(on_bus.it);
				pending_results.push_back(on_bus.known ? on_bus.want : guess);
				taken++;
			end
			if (!(item_valid && item_stall)) begin
				if (next_row < body_rows.size()
						&& ((taken >= 250 && taken < 400) || $urandom_range(0, 99) >= 15)) begin
					on_bus = body_rows[next_row];
					item <= on_bus.it;
					item_valid <= 1'b1;
					next_row++;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		result_t want;
		if (result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("out_byte", result.out_byte, want.out_byte);
				check_field("out_valid", 8'(result.out_valid), 8'(want.out_valid));
				check_field("finished", 8'(result.finished), 8'(want.finished));
				check_field("status", 8'(result.status), 8'(want.status));
				check_field("is_last", 8'(result.is_last), 8'(want.is_last));
			end
			checked <= checked + 1;
		end
		if (arst_n) begin
			result_stall <= !(checked >= 250 && checked < 400) && $urandom_range(0, 99) < 15;
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

endmodule
